### rtl/core/nlla_pkg.sv
// shared types and constants of the newline line assembler
// used by nlla_front, nlla_back and newline_line_assembler_fifo; no dependencies
package nlla_pkg;

  localparam int DATA_W  = 8;
  localparam int LIMIT_W = 6;

  localparam logic [DATA_W-1:0] NEWLINE_BYTE = 8'h0a;

  localparam logic [1:0] ST_ACCEPT   = 2'd0;
  localparam logic [1:0] ST_DROP     = 2'd1;
  localparam logic [1:0] ST_LINE     = 2'd2;
  localparam logic [1:0] ST_NOTREADY = 2'd3;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TAKE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [DATA_W-1:0] data;
  } cmd_t;

endpackage

### rtl/core/newline_line_assembler_fifo.sv
// top level of the newline line assembler: line limit register, front and back
// depends on nlla_pkg, nlla_front, nlla_back
//
// Bytes from a serial stream are queued in a ring fifo of QUEUE_DEPTH bytes and
// handed out as lines. An add word (tuser 0) answers with one word: accepted or
// dropped because full. A take word (tuser 1) answers with the line characters
// and a last-marked terminator, or with a single "no line ready" word. An add
// is answered from idle; a take of a line enters the pop state, then pops bytes
// from the fifo memory (its single read port pops one byte a cycle, output
// permitting), with a terminator of its own when it stops at the limit or on an
// empty fifo. A two-word command queue lets input words be taken while a line
// is still going out. The fifo memory is not cleared after reset.
module newline_line_assembler_fifo #(
  parameter int QUEUE_DEPTH = 256,
  parameter int LINE_MAX    = 63
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // byte_in
  input  logic [0:0]                   s_axis_tuser,   // action
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // char_out
  output logic [1:0]                   m_axis_tuser,   // status
  output logic                         m_axis_tlast,
  input  logic                         cfg_we,
  input  logic [nlla_pkg::LIMIT_W-1:0] cfg_wdata
);

  localparam logic [nlla_pkg::LIMIT_W-1:0] LIMIT_MAX = nlla_pkg::LIMIT_W'(LINE_MAX);

  logic [nlla_pkg::LIMIT_W-1:0] line_limit;
  logic [nlla_pkg::LIMIT_W-1:0] limit_eff;
  logic                         cmd_valid;
  logic                         cmd_ready;
  nlla_pkg::cmd_t               cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LIMIT_MAX;
    end else if (cfg_we) begin
      line_limit <= cfg_wdata;
    end
  end

  assign limit_eff = (line_limit > LIMIT_MAX) ? LIMIT_MAX : line_limit;

  nlla_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser[0]),
    .in_byte   (s_axis_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  nlla_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .limit      (limit_eff),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_char   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

### rtl/core/nlla_front.sv
// front end: takes input words, decodes them into commands, two-word command queue
// depends on nlla_pkg
module nlla_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [nlla_pkg::DATA_W-1:0] in_byte,
  output logic                        cmd_valid,
  input  logic                        cmd_ready,
  output nlla_pkg::cmd_t              cmd
);

  nlla_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pull;
  nlla_pkg::cmd_t decoded;

  always_comb begin
    decoded.kind = in_action ? nlla_pkg::CMD_TAKE : nlla_pkg::CMD_ADD;
    decoded.data = in_byte;
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pull      = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pull) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pull})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/nlla_back.sv
// back end: byte ring fifo in memory, fill and newline counts, line sequencer,
// output register; depends on nlla_pkg
module nlla_back #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [nlla_pkg::LIMIT_W-1:0] limit,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  nlla_pkg::cmd_t               cmd,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [nlla_pkg::DATA_W-1:0]  out_char,
  output logic                         out_last
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
  localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  logic [nlla_pkg::DATA_W-1:0] mem [QUEUE_DEPTH];

  state_t                       state, state_next;
  logic [AW-1:0]                rptr, rptr_next;
  logic [CW-1:0]                fill, fill_next;
  logic [CW-1:0]                nl, nl_next;
  logic [nlla_pkg::LIMIT_W-1:0] taken, taken_next;
  logic [nlla_pkg::LIMIT_W-1:0] lim, lim_next;
  logic                         full_mode, full_mode_next;
  logic [nlla_pkg::DATA_W-1:0]  rdata;

  logic                         out_free;
  logic                         is_full;
  logic [AW:0]                  wsum;
  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                rptr_inc;
  logic [AW-1:0]                rd_addr;
  logic [nlla_pkg::LIMIT_W-1:0] n_full;
  logic                         wr_en;
  logic                         pop;
  logic                         emit;
  logic [1:0]                   emit_st;
  logic [nlla_pkg::DATA_W-1:0]  emit_ch;
  logic                         emit_last;

  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == S_IDLE) && out_free;
  assign is_full   = (fill == DEPTH_C);
  assign wsum      = (AW + 1)'(rptr) + (AW + 1)'(fill);
  assign wr_addr   = (wsum >= DEPTH_W) ? AW'(wsum - DEPTH_W) : AW'(wsum);
  assign rptr_inc  = (rptr == LAST_ADDR) ? '0 : rptr + AW'(1);
  assign rd_addr   = pop ? rptr_inc : rptr;
  assign n_full    = (32'(limit) > QUEUE_DEPTH) ? nlla_pkg::LIMIT_W'(QUEUE_DEPTH) : limit;

  always_comb begin
    state_next     = state;
    rptr_next      = rptr;
    fill_next      = fill;
    nl_next        = nl;
    taken_next     = taken;
    lim_next       = lim;
    full_mode_next = full_mode;
    wr_en          = 1'b0;
    pop            = 1'b0;
    emit           = 1'b0;
    emit_st        = nlla_pkg::ST_LINE;
    emit_ch        = '0;
    emit_last      = 1'b1;
    case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          case (cmd.kind)
            nlla_pkg::CMD_ADD: begin
              emit = 1'b1;
              if (is_full) begin
                emit_st = nlla_pkg::ST_DROP;
              end else begin
                emit_st   = nlla_pkg::ST_ACCEPT;
                wr_en     = 1'b1;
                fill_next = fill + CW'(1);
                if (cmd.data == nlla_pkg::NEWLINE_BYTE) begin
                  nl_next = nl + CW'(1);
                end
              end
            end
            nlla_pkg::CMD_TAKE: begin
              if (limit == '0) begin
                emit = 1'b1;
              end else if (nl != '0) begin
                state_next     = S_POP;
                full_mode_next = 1'b0;
                lim_next       = limit;
                taken_next     = '0;
              end else if (is_full) begin
                state_next     = S_POP;
                full_mode_next = 1'b1;
                lim_next       = n_full;
                taken_next     = '0;
              end else begin
                emit    = 1'b1;
                emit_st = nlla_pkg::ST_NOTREADY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          emit = 1'b1;
          if (!full_mode && (taken == lim || fill == '0)) begin
            state_next = S_IDLE;
          end else begin
            pop = 1'b1;
            if (full_mode ? (taken + nlla_pkg::LIMIT_W'(1) == lim)
                          : (rdata == nlla_pkg::NEWLINE_BYTE)) begin
              state_next = S_IDLE;
            end else begin
              emit_ch    = rdata;
              emit_last  = 1'b0;
              taken_next = taken + nlla_pkg::LIMIT_W'(1);
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (pop) begin
      rptr_next = rptr_inc;
      fill_next = fill - CW'(1);
      if (rdata == nlla_pkg::NEWLINE_BYTE && nl != '0) begin
        nl_next = nl - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    taken     <= taken_next;
    lim       <= lim_next;
    full_mode <= full_mode_next;
    if (emit) begin
      out_status <= emit_st;
      out_char   <= emit_ch;
      out_last   <= emit_last;
    end
    if (rst) begin
      state     <= S_IDLE;
      rptr      <= '0;
      fill      <= '0;
      nl        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rptr  <= rptr_next;
      fill  <= fill_next;
      nl    <= nl_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
